/* rtl/core/spdq_pkg.sv */
// ----------------------------------------------------------------------------
// spdq_pkg - shared types and constants of the steering controller
// operand widths, serial unit control, sequencer states, register map
// ----------------------------------------------------------------------------
package spdq_pkg;

	typedef logic signed [15:0] lane_offset_t;
	typedef logic signed [15:0] steer_drive_t;

	// apb register map
	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_PROP_GAIN = 2'd0;
	localparam logic [1:0] REG_SQUARE_DIV = 2'd1;
	localparam logic [1:0] REG_DERIV_GAIN = 2'd2;

	localparam logic [15:0] PROP_GAIN_RST = 16'd512;
	localparam logic [15:0] SQUARE_DIV_RST = 16'd7680;
	localparam logic [15:0] DERIV_GAIN_RST = 16'd2560;

	// serial multiply / divide unit
	localparam int unsigned OPA_W = 40;
	localparam int unsigned MPL_W = 22;
	localparam int unsigned DVS_W = 16;
	localparam int unsigned RES_W = OPA_W + MPL_W;
	localparam int unsigned STEP_W = 6;

	localparam logic [STEP_W-1:0] MUL_STEPS = 6'd22;
	localparam logic [STEP_W-1:0] ERR_STEPS = 6'd22;
	localparam logic [STEP_W-1:0] QDIV_STEPS = 6'd40;
	localparam logic [STEP_W-1:0] FILT_STEPS = 6'd18;

	localparam logic [MPL_W-1:0] ERR_DIVISOR = 22'd3;
	localparam logic [MPL_W-1:0] FILT_DIVISOR = 22'd5;

	typedef enum logic {
		MDU_MUL,
		MDU_DIV
	} mdu_op_t;

	typedef struct packed {
		logic              start;
		mdu_op_t           op;
		logic [STEP_W-1:0] steps;
	} mdu_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR_GO,
		ST_ERR_WAIT,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_QDIV_GO,
		ST_QDIV_WAIT,
		ST_GAIN_GO,
		ST_GAIN_WAIT,
		ST_DER_GO,
		ST_DER_WAIT,
		ST_SUM,
		ST_RAW,
		ST_FILT_GO,
		ST_FILT_WAIT,
		ST_DONE
	} state_t;

endpackage

/* rtl/core/spdq_offset_if.sv */
// ----------------------------------------------------------------------------
// spdq_offset_if - lane offset channel
// valid / ready handshake carrying one signed lane offset per transaction
// ----------------------------------------------------------------------------
interface spdq_offset_if import spdq_pkg::*;;

	logic         valid;
	logic         ready;
	lane_offset_t lane_offset;

	modport source (output valid, output lane_offset, input ready);
	modport sink (input valid, input lane_offset, output ready);

endinterface

/* rtl/core/spdq_drive_if.sv */
// ----------------------------------------------------------------------------
// spdq_drive_if - steering drive channel
// valid / ready handshake carrying one filtered steering command per transaction
// ----------------------------------------------------------------------------
interface spdq_drive_if import spdq_pkg::*;;

	logic         valid;
	logic         ready;
	steer_drive_t steer_drive;

	modport source (output valid, output steer_drive, input ready);
	modport sink (input valid, input steer_drive, output ready);

endinterface

/* rtl/core/spdq_mdu.sv */
// ----------------------------------------------------------------------------
// spdq_mdu - bit-serial multiply / divide unit
// shift-add multiply, one multiplier bit per cycle; restoring divide,
// one quotient bit per cycle with a left-aligned dividend
// ----------------------------------------------------------------------------
module spdq_mdu import spdq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  mdu_req_t         req,
	input  logic [OPA_W-1:0] opa,
	input  logic [MPL_W-1:0] opb,
	output logic             done,
	output logic [RES_W-1:0] result
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	mdu_op_t           op_q;

	logic [OPA_W-1:0] opa_q;
	logic [OPA_W-1:0] acc_q;
	logic [MPL_W-1:0] mp_q;
	logic [OPA_W-1:0] dq_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [OPA_W:0] madd;
	logic [DVS_W:0] rem_sh;
	logic [DVS_W:0] rem_nx;
	logic           ge;

	assign madd = {1'b0, acc_q} + (mp_q[0] ? {1'b0, opa_q} : '0);
	assign rem_sh = {rem_q, dq_q[OPA_W-1]};
	assign ge = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= MDU_MUL;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.steps;
				op_q <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			opa_q <= opa;
			acc_q <= '0;
			mp_q <= opb;
			dq_q <= opa;
			rem_q <= '0;
			dvs_q <= opb[DVS_W-1:0];
		end else if (busy_q) begin
			if (op_q == MDU_MUL) begin
				{acc_q, mp_q} <= {madd, mp_q[MPL_W-1:1]};
			end else begin
				dq_q <= {dq_q[OPA_W-2:0], ge};
				rem_q <= rem_nx[DVS_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign result = (op_q == MDU_MUL) ? {acc_q, mp_q} : RES_W'(dq_q);

endmodule

/* rtl/core/steering_pd_quadratic_gain_lowpass.sv */
// ----------------------------------------------------------------------------
// steering_pd_quadratic_gain_lowpass - pd steering with quadratic gain and low-pass
// one offset is in work at a time: a new one is taken only after the drive result
// of the last one is loaded into the output register
// the work is done by the shared bit-serial multiply / divide unit:
// six operations of 22, 22, 40, 22, 22 and 18 steps, run one after another
// reset: gains return to 2.0, 30.0 and 10.0 (q8.8), last error and last drive to 0
// ----------------------------------------------------------------------------
module steering_pd_quadratic_gain_lowpass import spdq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	spdq_offset_if.sink       meas,
	spdq_drive_if.source      cmd,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic [15:0] SAT_POS = 16'h7fff;
	localparam logic [15:0] SAT_NEG = 16'h8000;

	state_t state_q;
	state_t state_d;

	logic [15:0] prop_gain_q;
	logic [15:0] square_div_q;
	logic [15:0] deriv_gain_q;
	logic        cfg_wr;

	mdu_req_t         req;
	logic [OPA_W-1:0] opa;
	logic [MPL_W-1:0] opb;
	logic             mdu_done;
	logic [RES_W-1:0] mdu_res;

	logic [15:0] off_mag_q;
	logic        err_neg_q;
	logic [19:0] err_mag_q;
	logic [39:0] work_q;
	logic [39:0] gain_q;
	logic [60:0] prod_q;
	logic        dneg_q;
	logic [37:0] dprod_q;
	logic [61:0] sum_q;
	logic        rneg_q;
	logic [15:0] rmag_q;
	logic        nneg_q;
	logic [15:0] filt_q;
	logic [20:0] prev_error_q;
	logic [15:0] prev_drive_q;
	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic        out_load;

	logic [15:0] off_raw;
	logic [15:0] off_mag;
	logic [20:0] err_s;
	logic [21:0] diff;
	logic [21:0] dmag;
	logic [15:0] sq_div_eff;
	logic [61:0] p1;
	logic [61:0] p2;
	logic [61:0] p1s;
	logic [61:0] p2s;
	logic [61:0] smag;
	logic [45:0] sq_trunc;
	logic [15:0] sat_lim;
	logic [15:0] rmag;
	logic [18:0] r19;
	logic [18:0] r19s;
	logic [18:0] num;
	logic [17:0] nmag;
	logic [15:0] q16;
	logic [15:0] filt;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q <= PROP_GAIN_RST;
			square_div_q <= SQUARE_DIV_RST;
			deriv_gain_q <= DERIV_GAIN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[ADDR_W-1:2])
				REG_PROP_GAIN:  prop_gain_q <= pwdata[15:0];
				REG_SQUARE_DIV: square_div_q <= pwdata[15:0];
				REG_DERIV_GAIN: deriv_gain_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[ADDR_W-1:2])
			REG_PROP_GAIN:  prdata = {16'd0, prop_gain_q};
			REG_SQUARE_DIV: prdata = {16'd0, square_div_q};
			REG_DERIV_GAIN: prdata = {16'd0, deriv_gain_q};
			default:        prdata = '0;
		endcase
	end

	// shared serial arithmetic
	spdq_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (opb),
		.done   (mdu_done),
		.result (mdu_res)
	);

	// operand shaping
	assign off_raw = meas.lane_offset;
	assign off_mag = off_raw[15] ? (~off_raw + 16'd1) : off_raw;
	assign err_s = err_neg_q ? (~{1'b0, err_mag_q} + 21'd1) : {1'b0, err_mag_q};
	assign diff = {err_s[20], err_s} - {prev_error_q[20], prev_error_q};
	assign dmag = diff[21] ? (~diff + 22'd1) : diff;
	assign sq_div_eff = (square_div_q == 16'd0) ? 16'd1 : square_div_q;

	assign p1 = {1'b0, prod_q};
	assign p2 = {24'd0, dprod_q};
	assign p1s = err_neg_q ? (~p1 + 62'd1) : p1;
	assign p2s = dneg_q ? (~p2 + 62'd1) : p2;

	// truncate toward zero, then clamp to 16 bits
	assign smag = sum_q[61] ? (~sum_q + 62'd1) : sum_q;
	assign sq_trunc = smag[61:16];
	assign sat_lim = sum_q[61] ? SAT_NEG : SAT_POS;
	assign rmag = (sq_trunc > 46'(sat_lim)) ? sat_lim : sq_trunc[15:0];

	// low-pass numerator 4*raw + last drive
	assign r19 = {1'b0, rmag_q, 2'b00};
	assign r19s = rneg_q ? (~r19 + 19'd1) : r19;
	assign num = r19s + {{3{prev_drive_q[15]}}, prev_drive_q};
	assign nmag = num[18] ? 18'(~num + 19'd1) : num[17:0];

	assign q16 = mdu_res[15:0];
	assign filt = nneg_q ? (~q16 + 16'd1) : q16;

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || cmd.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (meas.valid) state_d = ST_ERR_GO;
			ST_ERR_GO:    state_d = ST_ERR_WAIT;
			ST_ERR_WAIT:  if (mdu_done) state_d = ST_SQ_GO;
			ST_SQ_GO:     state_d = ST_SQ_WAIT;
			ST_SQ_WAIT:   if (mdu_done) state_d = ST_QDIV_GO;
			ST_QDIV_GO:   state_d = ST_QDIV_WAIT;
			ST_QDIV_WAIT: if (mdu_done) state_d = ST_GAIN_GO;
			ST_GAIN_GO:   state_d = ST_GAIN_WAIT;
			ST_GAIN_WAIT: if (mdu_done) state_d = ST_DER_GO;
			ST_DER_GO:    state_d = ST_DER_WAIT;
			ST_DER_WAIT:  if (mdu_done) state_d = ST_SUM;
			ST_SUM:       state_d = ST_RAW;
			ST_RAW:       state_d = ST_FILT_GO;
			ST_FILT_GO:   state_d = ST_FILT_WAIT;
			ST_FILT_WAIT: if (mdu_done) state_d = ST_DONE;
			ST_DONE:      if (out_load) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.start = 1'b0;
		req.op = MDU_MUL;
		req.steps = MUL_STEPS;
		opa = '0;
		opb = '0;
		meas.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				meas.ready = 1'b1;
			end
			ST_ERR_GO: begin
				req.start = 1'b1;
				req.op = MDU_DIV;
				req.steps = ERR_STEPS;
				opa = {off_mag_q, 24'd0};
				opb = ERR_DIVISOR;
			end
			ST_SQ_GO: begin
				req.start = 1'b1;
				opa = {20'd0, err_mag_q};
				opb = {2'd0, err_mag_q};
			end
			ST_QDIV_GO: begin
				req.start = 1'b1;
				req.op = MDU_DIV;
				req.steps = QDIV_STEPS;
				opa = work_q;
				opb = {6'd0, sq_div_eff};
			end
			ST_GAIN_GO: begin
				req.start = 1'b1;
				opa = gain_q;
				opb = {2'd0, err_mag_q};
			end
			ST_DER_GO: begin
				req.start = 1'b1;
				opa = {24'd0, deriv_gain_q};
				opb = dmag;
			end
			ST_FILT_GO: begin
				req.start = 1'b1;
				req.op = MDU_DIV;
				req.steps = FILT_STEPS;
				opa = {nmag, 22'd0};
				opb = FILT_DIVISOR;
			end
			default: ;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (meas.valid) begin
					off_mag_q <= off_mag;
					err_neg_q <= !off_raw[15] && (off_raw != 16'd0);
				end
			end
			ST_ERR_WAIT:  if (mdu_done) err_mag_q <= mdu_res[19:0];
			ST_SQ_WAIT:   if (mdu_done) work_q <= mdu_res[39:0];
			ST_QDIV_WAIT: if (mdu_done) gain_q <= mdu_res[39:0] + {24'd0, prop_gain_q};
			ST_GAIN_WAIT: if (mdu_done) prod_q <= mdu_res[60:0];
			ST_DER_GO:    dneg_q <= diff[21];
			ST_DER_WAIT:  if (mdu_done) dprod_q <= mdu_res[37:0];
			ST_SUM:       sum_q <= p1s + p2s;
			ST_RAW: begin
				rneg_q <= sum_q[61];
				rmag_q <= rmag;
			end
			ST_FILT_GO:   nneg_q <= num[18];
			ST_FILT_WAIT: if (mdu_done) filt_q <= filt;
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= filt_q;
		end
	end

	// kept state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			prev_drive_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				prev_error_q <= err_s;
				prev_drive_q <= filt_q;
				out_valid_q <= 1'b1;
			end else if (cmd.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cmd.valid = out_valid_q;
	assign cmd.steer_drive = out_data_q;

endmodule

/* rtl/core/spdq_chk.sv */
// ----------------------------------------------------------------------------
// spdq_chk - port-level checks of the steering controller
// watches the channels and the configuration port of the top level
// ----------------------------------------------------------------------------
module spdq_chk import spdq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              meas_valid,
	input logic              meas_ready,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic              pready,
	input logic [ADDR_W-1:0] paddr,
	input logic [31:0]       pwdata,
	input logic [31:0]       prdata
);

	logic reg_hit;
	logic cfg_wr;

	assign reg_hit = (paddr[ADDR_W-1:2] == REG_PROP_GAIN)
		|| (paddr[ADDR_W-1:2] == REG_SQUARE_DIV)
		|| (paddr[ADDR_W-1:2] == REG_DERIV_GAIN);
	assign cfg_wr = psel && penable && pwrite && pready;

	// one transaction in flight: input closes after it is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(meas_valid && meas_ready) |=> !meas_ready)
		else $error("offset taken while previous one still in work");

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_ready) |=> cmd_valid)
		else $error("drive result dropped before transaction");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_hit) |=>
		((paddr != $past(paddr)) || (prdata[15:0] == $past(pwdata[15:0]))))
		else $error("written gain not read back");

	a_rd_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_hit) |=> ((paddr != $past(paddr)) || (prdata[31:16] == 16'd0)))
		else $error("gain register read back with upper bits set");

endmodule

bind steering_pd_quadratic_gain_lowpass spdq_chk u_spdq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.meas_valid (meas.valid),
	.meas_ready (meas.ready),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.pready     (pready),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata)
);

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the quadratic gain pd steering block
// lane offsets are driven through a queue with random gaps while the drive
// channel stalls at random; each offset transaction is run through a local
// model of the error, gain scheduling, saturation and low-pass stages, and
// every drive transaction is compared against the oldest predicted command.
// gains are rewritten over apb between phases, extremes included
// ----------------------------------------------------------------------------
module tb_top;
	import spdq_pkg::*;

	localparam int ERR_FRAC = 8;
	localparam int WDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 200;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 60;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	spdq_offset_if meas_if ();
	spdq_drive_if  cmd_if ();

	logic         offset_valid = 1'b0;
	lane_offset_t offset_data = '0;
	logic         offset_taken = 1'b0;
	logic         drive_ready = 1'b0;
	int unsigned  send_gap = 0;
	int unsigned  stall = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  fail_cnt = 0;
	bit           calm = 1'b0;

	lane_offset_t offset_pend[$];
	steer_drive_t drive_exp[$];

	// local copy of gains and controller history
	logic [15:0] prop_gain_q = PROP_GAIN_RST;
	logic [15:0] sq_div_q = SQUARE_DIV_RST;
	logic [15:0] deriv_gain_q = DERIV_GAIN_RST;
	longint      prev_err_q = 0;
	longint      prev_drive_q = 0;

	assign meas_if.valid = offset_valid;
	assign meas_if.lane_offset = offset_data;
	assign cmd_if.ready = drive_ready;

	steering_pd_quadratic_gain_lowpass u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.meas    (meas_if),
		.cmd     (cmd_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic steer_drive_t steer_step(lane_offset_t offset);
		longint err, mag, sq, dvs, sqterm, gain, prod, sum, raw, filt;
		err = (-longint'(offset) * (longint'(1) << ERR_FRAC)) / 12;
		mag = (err < 0) ? -err : err;
		sq = mag * mag;
		dvs = (sq_div_q == 16'd0) ? longint'(1) : longint'(sq_div_q);
		if (2 * ERR_FRAC >= 16)
			sqterm = sq / (dvs << (2 * ERR_FRAC - 16));
		else
			sqterm = (sq << (16 - 2 * ERR_FRAC)) / dvs;
		gain = sqterm + longint'(prop_gain_q);
		if (gain != 0 && mag > (longint'(1) << 62) / gain) begin
			raw = (err < 0) ? -32768 : 32767;
		end else begin
			prod = gain * mag;
			if (err < 0)
				prod = -prod;
			sum = prod + longint'(deriv_gain_q) * (err - prev_err_q);
			// signed division truncates toward zero
			raw = clamp16(sum / (longint'(1) << (8 + ERR_FRAC)));
		end
		filt = clamp16((4 * raw + prev_drive_q) / 5);
		prev_err_q = err;
		prev_drive_q = filt;
		return steer_drive_t'(filt);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 120);
	endfunction

	function automatic lane_offset_t rand_offset(lane_offset_t prev);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25) return lane_offset_t'(int'($urandom_range(0, 400)) - 200);
		if (r < 50) return lane_offset_t'(int'($urandom_range(0, 6000)) - 3000);
		if (r < 75) return lane_offset_t'(int'(prev) + int'($urandom_range(0, 64)) - 32);
		return lane_offset_t'($urandom);
	endfunction

	function automatic logic [15:0] pick_gain();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15) return 16'd0;
		if (r < 30) return 16'hFFFF;
		if (r < 45) return 16'($urandom_range(1, 1024));
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_divisor();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) return 16'd0;
		if (r < 25) return 16'd1;
		if (r < 40) return 16'hFFFF;
		if (r < 60) return 16'($urandom_range(1, 64));
		return 16'($urandom_range(1, 65535));
	endfunction

	task automatic note_fail(string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = {16'd0, value};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_PROP_GAIN: prop_gain_q = value;
			REG_SQUARE_DIV: sq_div_q = value;
			REG_DERIV_GAIN: deriv_gain_q = value;
			default: ;
		endcase
	endtask

	task automatic write_gains(logic [15:0] kp, logic [15:0] kq, logic [15:0] kd);
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_SQUARE_DIV, kq);
		write_reg(REG_DERIV_GAIN, kd);
	endtask

	task automatic settle();
		while (offset_pend.size() != 0 || offset_valid || drive_exp.size() != 0)
			@(posedge clk);
	endtask

	// offset driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_valid <= 1'b0;
			offset_data <= '0;
			send_gap <= 0;
		end else if (!offset_valid || offset_taken) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				offset_valid <= 1'b0;
			end else if (offset_pend.size() != 0) begin
				offset_valid <= 1'b1;
				offset_data <= offset_pend.pop_front();
				send_gap <= pick_gap();
			end else begin
				offset_valid <= 1'b0;
			end
		end
	end

	// drive channel back-pressure
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_ready <= 1'b0;
			stall <= 0;
		end else if (stall != 0) begin
			stall <= stall - 1;
			drive_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 15) begin
			stall <= pick_gap();
			drive_ready <= 1'b0;
		end else begin
			drive_ready <= 1'b1;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		steer_drive_t want;
		offset_taken <= meas_if.valid && meas_if.ready;
		if (meas_if.valid && meas_if.ready)
			drive_exp.push_back(steer_step(meas_if.lane_offset));
		if (cmd_if.valid && cmd_if.ready) begin
			if (drive_exp.size() == 0) begin
				note_fail($sformatf("unexpected drive transaction %0d", cmd_if.steer_drive));
			end else begin
				want = drive_exp.pop_front();
				if (cmd_if.steer_drive !== want)
					note_fail($sformatf("steer_drive mismatch: expected %0d, got %0d",
						want, cmd_if.steer_drive));
			end
		end
	end

	always @(posedge clk) begin
		if ((meas_if.valid && meas_if.ready) || (cmd_if.valid && cmd_if.ready)
				|| (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles < WDOG_LIMIT) begin
			idle_cycles <= idle_cycles + 1;
		end else begin
			$display("steering_pd_quadratic_gain_lowpass test failed");
			$finish;
		end
	end

	initial begin
		lane_offset_t last_off;
		last_off = '0;
		repeat (9) @(posedge clk);
		#2 arst_n = 1'b1;

		// reset gains: zero, unit steps, sign edges and full-scale saturation
		offset_pend = '{16'sd0, 16'sd1, -16'sd1, 16'sd11, 16'sd12, -16'sd12, 16'sd13,
			16'sd100, -16'sd100, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
			16'sd0, 16'sd0, 16'sd2000};
		settle();

		// writes beyond the register map are dropped
		write_reg(REG_UNUSED, 16'hFFFF);
		write_gains(16'd0, 16'd1, 16'd0);
		offset_pend = '{16'sd32767, -16'sd32768, 16'sd12, -16'sd12, 16'sd0};
		settle();

		// zero divisor acts as one, all other gains at maximum
		write_gains(16'hFFFF, 16'd0, 16'hFFFF);
		offset_pend = '{16'sd1, -16'sd1, 16'sd32767, -16'sd32768};
		settle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 0)
				write_gains(PROP_GAIN_RST, SQUARE_DIV_RST, DERIV_GAIN_RST);
			else if (ph == 1)
				write_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
			else
				write_gains(pick_gain(), pick_divisor(), pick_gain());
			calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				last_off = rand_offset(last_off);
				offset_pend.push_back(last_off);
			end
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && drive_exp.size() == 0)
			$display("steering_pd_quadratic_gain_lowpass test passed");
		else
			$display("steering_pd_quadratic_gain_lowpass test failed");
		$finish;
	end

endmodule

/* files.f */
rtl/core/spdq_pkg.sv
rtl/core/spdq_offset_if.sv
rtl/core/spdq_drive_if.sv
rtl/core/spdq_mdu.sv
rtl/core/steering_pd_quadratic_gain_lowpass.sv
rtl/core/spdq_chk.sv
bench/tb_top.sv
